// ----- hdl/vmf_pkg.sv -----
// vmf_pkg: shared constants, codes and fsm type for the voxel fill block
// no dependencies
`timescale 1ns / 1ps

package vmf_pkg;

	localparam int VOLUME_DEPTH_DEF = 32768;
	localparam int SAMPLE_WIDTH_DEF = 16;

	localparam int EXT_W      = 11;
	localparam int THR_W      = 5;
	localparam int IDX_W      = 15;
	localparam int IN_VAL_W   = 16;
	localparam int FILL_W     = 16;
	localparam int NBR_CNT_W  = 5;
	localparam int DIVISOR_W  = NBR_CNT_W + 1;
	localparam int NBR_MAX    = 26;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_RUN   = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_SIZE_X  = 2'd0,
		REG_SIZE_Y  = 2'd1,
		REG_SIZE_Z  = 2'd2,
		REG_MIN_NBR = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PLANE,
		ST_VOL,
		ST_SIZE,
		ST_CENTER,
		ST_CHECK,
		ST_NBR,
		ST_NLAST,
		ST_DECIDE,
		ST_DIV,
		ST_RESP
	} state_t;

endpackage

// ----- hdl/vmf_voxel_ram.sv -----
// vmf_voxel_ram: voxel store, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module vmf_voxel_ram #(
	parameter int DEPTH = 32768,
	parameter int WIDTH = 17,
	parameter int AW    = 15
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/vmf_mean_div.sv -----
// vmf_mean_div: restoring divider, one quotient bit per cycle
// depends on vmf_pkg for the divisor width
`timescale 1ns / 1ps

module vmf_mean_div import vmf_pkg::*; #(
	parameter int DVD_W = 22
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DVD_W-1:0]     dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic                 busy,
	output logic                 done,
	output logic [DVD_W-1:0]     quotient
);

	localparam int CW = $clog2(DVD_W + 1);

	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic [DVD_W-1:0]     quo_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIVISOR_W:0]   trial;
	logic [DIVISOR_W:0]   diff;
	logic                 take;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign take  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DVD_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CW'(1);
			busy_q <= (cnt_q != CW'(1));
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], take};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- hdl/voxel_missing_fill_neighbor_mean.sv -----
// voxel_missing_fill_neighbor_mean: write and read each have an accept step, then a response.
// run: plane, volume and size setup, then a center read and check per interior voxel;
// a missing one reads its neighbors one per cycle through the single ram read port and,
// if enough are present, is filled by the bit-serial divider; then the response.
// reset clears control and sets size 32x32x32, threshold 0; the voxel ram is not cleared
// and holds undefined data until written. depends on vmf_pkg, vmf_voxel_ram, vmf_mean_div
`timescale 1ns / 1ps

module voxel_missing_fill_neighbor_mean import vmf_pkg::*; #(
	parameter int VOLUME_DEPTH = VOLUME_DEPTH_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [EXT_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // voxel_index, sample_value, sample_missing
	input  logic [1:0]       s_tuser,   // command
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [39:0]      m_tdata,   // read_value, read_missing, filled_count, zero pad
	output logic             m_tuser    // status
);

	localparam int AW    = (VOLUME_DEPTH > 1) ? $clog2(VOLUME_DEPTH) : 1;
	localparam int SW    = SAMPLE_WIDTH;
	localparam int MW    = SW + 1;
	localparam int SUM_W = SW + 5;
	localparam int DVD_W = SW + 6;

	state_t state_q, state_d;

	logic [EXT_W-1:0] sx_q, sy_q, sz_q;
	logic [THR_W-1:0] thr_q;

	logic [IDX_W-1:0]           in_idx;
	logic signed [IN_VAL_W-1:0] in_val;
	logic                       in_miss;
	logic                       in_range;
	logic [AW-1:0]              in_addr;
	logic signed [SW-1:0]       in_wrap;
	logic                       s_acc;

	logic [1:0]        cmd_q;
	logic              status_q;
	logic [FILL_W-1:0] filled_q;

	logic [2*EXT_W-1:0] plane_q;
	logic [3*EXT_W-1:0] vol_q;
	logic [AW-1:0]      plane_a_q, step_y_q, step_z_q;
	logic [EXT_W-1:0]   xe_q, ye_q, ze_q;
	logic [EXT_W-1:0]   x_q, y_q, z_q;
	logic [AW-1:0]      c_q, na_q;
	logic [1:0]         dx_q, dy_q, dz_q;
	logic               nbr_vld_s1;
	logic signed [SUM_W-1:0] sum_q;
	logic [NBR_CNT_W-1:0]    cnt_q;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [MW-1:0] mem_wdata, rd_data;
	logic signed [SW-1:0] rd_val;
	logic          rd_miss;

	logic             div_start, div_busy, div_done;
	logic [DVD_W-1:0] div_quo, dividend;
	logic [SUM_W-1:0] sum_mag;
	logic             sum_neg;
	logic [SW-1:0]    mean_mag;
	logic [SW-1:0]    mean;

	logic last_vox, fill_ok, short_ext, advance, out_load;

	logic [15:0] out_value_q;
	logic        out_missing_q;
	logic [FILL_W-1:0] out_filled_q;
	logic        out_status_q;
	logic        m_tvalid_q;

	assign in_idx   = s_tdata[14:0];
	assign in_val   = s_tdata[30:15];
	assign in_miss  = s_tdata[31];
	assign in_range = {17'd0, in_idx} < 32'(VOLUME_DEPTH);
	assign in_addr  = AW'({17'd0, in_idx});
	assign in_wrap  = SW'(in_val);

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	assign rd_val  = rd_data[SW-1:0];
	assign rd_miss = rd_data[SW];

	assign last_vox  = (x_q == xe_q) && (y_q == ye_q) && (z_q == ze_q);
	assign fill_ok   = cnt_q > thr_q;
	assign short_ext = (sx_q < EXT_W'(3)) || (sy_q < EXT_W'(3)) || (sz_q < EXT_W'(3));

	assign sum_neg  = sum_q[SUM_W-1];
	assign sum_mag  = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign dividend = {sum_mag, 1'b0} + DVD_W'(cnt_q);
	assign mean_mag = div_quo[SW-1:0];
	assign mean     = sum_neg ? (-mean_mag) : mean_mag;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q  <= EXT_W'(32);
			sy_q  <= EXT_W'(32);
			sz_q  <= EXT_W'(32);
			thr_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIZE_X:  sx_q  <= cfg_wdata;
				REG_SIZE_Y:  sy_q  <= cfg_wdata;
				REG_SIZE_Z:  sz_q  <= cfg_wdata;
				REG_MIN_NBR: thr_q <= cfg_wdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					state_d = (s_tuser == CMD_RUN) ? ST_PLANE : ST_RESP;
				end
			end
			ST_PLANE: state_d = ST_VOL;
			ST_VOL:   state_d = ST_SIZE;
			ST_SIZE: begin
				if ((vol_q > 33'(VOLUME_DEPTH)) || short_ext) begin
					state_d = ST_RESP;
				end else begin
					state_d = ST_CENTER;
				end
			end
			ST_CENTER: state_d = ST_CHECK;
			ST_CHECK: begin
				if (rd_miss) begin
					state_d = ST_NBR;
				end else begin
					state_d = last_vox ? ST_RESP : ST_CENTER;
				end
			end
			ST_NBR: begin
				if (dx_q == 2'd2 && dy_q == 2'd2 && dz_q == 2'd2) begin
					state_d = ST_NLAST;
				end
			end
			ST_NLAST: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (fill_ok) begin
					state_d = ST_DIV;
				end else begin
					state_d = last_vox ? ST_RESP : ST_CENTER;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = last_vox ? ST_RESP : ST_CENTER;
				end
			end
			ST_RESP: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = c_q;
		mem_wdata = {1'b0, mean};
		mem_re    = 1'b0;
		mem_raddr = c_q;
		div_start = 1'b0;
		advance   = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_acc && in_range) begin
					if (s_tuser == CMD_WRITE) begin
						mem_we    = 1'b1;
						mem_waddr = in_addr;
						mem_wdata = in_miss ? {1'b1, {SW{1'b0}}} : {1'b0, in_wrap};
					end
					if (s_tuser == CMD_READ) begin
						mem_re    = 1'b1;
						mem_raddr = in_addr;
					end
				end
			end
			ST_CENTER: mem_re = 1'b1;
			ST_CHECK:  advance = !rd_miss;
			ST_NBR: begin
				mem_re    = 1'b1;
				mem_raddr = na_q;
			end
			ST_DECIDE: begin
				div_start = fill_ok;
				advance   = !fill_ok;
			end
			ST_DIV: begin
				mem_we  = div_done;
				advance = div_done;
			end
			ST_RESP: out_load = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			nbr_vld_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			nbr_vld_s1 <= (state_q == ST_NBR);
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// scan datapath
	always_ff @(posedge clk) begin
		if (s_acc) begin
			cmd_q    <= s_tuser;
			filled_q <= '0;
			status_q <= ((s_tuser == CMD_WRITE) || (s_tuser == CMD_READ)) && !in_range;
		end
		if (state_q == ST_PLANE) begin
			plane_q <= sx_q * sy_q;
		end
		if (state_q == ST_VOL) begin
			vol_q <= plane_q * sz_q;
		end
		if (state_q == ST_SIZE) begin
			status_q  <= vol_q > 33'(VOLUME_DEPTH);
			plane_a_q <= AW'(plane_q);
			step_y_q  <= AW'(sx_q) - AW'(2);
			step_z_q  <= AW'(plane_q) - AW'(sx_q) - AW'(sx_q) - AW'(2);
			c_q       <= AW'(plane_q) + AW'(sx_q) + AW'(1);
			xe_q      <= sx_q - EXT_W'(2);
			ye_q      <= sy_q - EXT_W'(2);
			ze_q      <= sz_q - EXT_W'(2);
			x_q       <= EXT_W'(1);
			y_q       <= EXT_W'(1);
			z_q       <= EXT_W'(1);
		end
		if (state_q == ST_CHECK && rd_miss) begin
			na_q  <= c_q - plane_a_q - AW'(sx_q) - AW'(1);
			dx_q  <= '0;
			dy_q  <= '0;
			dz_q  <= '0;
			sum_q <= '0;
			cnt_q <= '0;
		end
		if (state_q == ST_NBR) begin
			if (dx_q != 2'd2) begin
				dx_q <= dx_q + 2'd1;
				na_q <= na_q + AW'(1);
			end else if (dy_q != 2'd2) begin
				dx_q <= '0;
				dy_q <= dy_q + 2'd1;
				na_q <= na_q + step_y_q;
			end else begin
				dx_q <= '0;
				dy_q <= '0;
				dz_q <= dz_q + 2'd1;
				na_q <= na_q + step_z_q;
			end
		end
		if (nbr_vld_s1 && !rd_miss) begin
			sum_q <= sum_q + SUM_W'(rd_val);
			cnt_q <= cnt_q + NBR_CNT_W'(1);
		end
		if (state_q == ST_DIV && div_done && filled_q != {FILL_W{1'b1}}) begin
			filled_q <= filled_q + FILL_W'(1);
		end
		if (advance && !last_vox) begin
			if (x_q != xe_q) begin
				x_q <= x_q + EXT_W'(1);
				c_q <= c_q + AW'(1);
			end else if (y_q != ye_q) begin
				x_q <= EXT_W'(1);
				y_q <= y_q + EXT_W'(1);
				c_q <= c_q + AW'(3);
			end else begin
				x_q <= EXT_W'(1);
				y_q <= EXT_W'(1);
				z_q <= z_q + EXT_W'(1);
				c_q <= c_q + AW'(3) + AW'(sx_q) + AW'(sx_q);
			end
		end
	end

	// response word
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q   <= (cmd_q == CMD_READ && !status_q) ? 16'(rd_val) : 16'd0;
			out_missing_q <= (cmd_q == CMD_READ && !status_q) && rd_miss;
			out_filled_q  <= (cmd_q == CMD_RUN) ? filled_q : '0;
			out_status_q  <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, out_filled_q, out_missing_q, out_value_q};
	assign m_tuser  = out_status_q;

	vmf_voxel_ram #(
		.DEPTH (VOLUME_DEPTH),
		.WIDTH (MW),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	vmf_mean_div #(
		.DVD_W (DVD_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  ({cnt_q, 1'b0}),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_busy || div_done))
		else $error("fill waits on an idle divider");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider result outside the fill step");

	a_nbr_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NBR) |=> nbr_vld_s1)
		else $error("neighbor read not followed by accumulate");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) |-> (cnt_q <= NBR_CNT_W'(NBR_MAX)))
		else $error("neighbor count beyond cube");

	a_fill_present: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q == ST_DIV) |-> (rd_miss == $past(rd_miss)))
		else $error("read data moved during fill");

endmodule

// ----- tb/tb_voxel_missing_fill_neighbor_mean.sv -----
// tb_voxel_missing_fill_neighbor_mean: self-checking bench for the voxel fill block, with its
// own shadow of the voxel store and the sizes, directed and random command streams
// depends on vmf_pkg and voxel_missing_fill_neighbor_mean
`timescale 1ns / 1ps

module tb_voxel_missing_fill_neighbor_mean;
	import vmf_pkg::*;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int VOX_DEPTH = VOLUME_DEPTH_DEF;
	localparam longint TIMEOUT_NS = 64'd18000000;

	typedef struct packed {
		logic signed [15:0] value;
		logic               miss;
		logic [15:0]        filled;
		logic               status;
	} voxel_reply_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [EXT_W-1:0] cfg_wdata;
	logic             s_tvalid;
	logic             s_tready;
	logic [31:0]      s_tdata;   // voxel_index, sample_value, sample_missing
	logic [1:0]       s_tuser;   // command
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [39:0]      m_tdata;   // read_value, read_missing, filled_count, zero pad
	logic             m_tuser;   // status

	logic signed [15:0] vox_val [VOX_DEPTH];
	bit                 vox_miss [VOX_DEPTH];
	bit                 vox_known [VOX_DEPTH];
	int                 known_list [$];
	logic [EXT_W-1:0]   ext_x, ext_y, ext_z;
	logic [THR_W-1:0]   nbr_thresh;

	voxel_reply_t pending_replies [$];
	int mismatches = 0;
	int word_gap_pct;
	int stall_pct;
	int rx_hold = 0;

	voxel_missing_fill_neighbor_mean uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int pick_gap(int pct);
		if ($urandom_range(99, 0) >= pct)
			return 0;
		if ($urandom_range(9, 0) == 0)
			return $urandom_range(40, 8);
		return $urandom_range(3, 1);
	endfunction

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(9, 0))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// in-place walk over the interior, x fastest
	function automatic logic [15:0] fill_volume();
		int sx, sy, sz, plane, c, p, n, filled;
		longint sum, mag, q;
		sx = int'(ext_x);
		sy = int'(ext_y);
		sz = int'(ext_z);
		filled = 0;
		if (sx < 3 || sy < 3 || sz < 3)
			return '0;
		plane = sx * sy;
		for (int z = 1; z < sz - 1; z++)
			for (int y = 1; y < sy - 1; y++)
				for (int x = 1; x < sx - 1; x++) begin
					c = x + y * sx + z * plane;
					if (vox_miss[c]) begin
						sum = 0;
						n = 0;
						for (int dz = -1; dz <= 1; dz++)
							for (int dy = -1; dy <= 1; dy++)
								for (int dx = -1; dx <= 1; dx++) begin
									if (dx != 0 || dy != 0 || dz != 0) begin
										p = c + dx + dy * sx + dz * plane;
										if (!vox_miss[p]) begin
											sum += vox_val[p];
											n++;
										end
									end
								end
						if (n > int'(nbr_thresh)) begin
							mag = (sum < 0) ? -sum : sum;
							q = (mag * 2 + n) / (2 * n);
							vox_val[c] = 16'((sum < 0) ? -q : q);
							vox_miss[c] = 1'b0;
							if (filled < 65535)
								filled++;
						end
					end
				end
		return 16'(filled);
	endfunction

	function automatic voxel_reply_t voxel_reply(logic [1:0] cmd, logic [14:0] idx,
			logic signed [15:0] val, logic miss);
		voxel_reply_t r;
		longint vol;
		r = '0;
		case (cmd)
			CMD_WRITE: begin
				vox_val[idx] = miss ? 16'sd0 : val;
				vox_miss[idx] = miss;
				if (!vox_known[idx]) begin
					vox_known[idx] = 1'b1;
					known_list.push_back(int'(idx));
				end
			end
			CMD_READ: begin
				r.value = vox_val[idx];
				r.miss = vox_miss[idx];
			end
			CMD_RUN: begin
				vol = longint'(ext_x) * longint'(ext_y) * longint'(ext_z);
				if (vol > VOX_DEPTH)
					r.status = 1'b1;
				else
					r.filled = fill_volume();
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic issue_word(input logic [1:0] cmd, input logic [14:0] idx,
			input logic signed [15:0] val, input logic miss);
		int gap;
		gap = pick_gap(word_gap_pct);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {miss, val, idx};
		do @(posedge clk); while (!s_tready);
		pending_replies.push_back(voxel_reply(cmd, idx, val, miss));
	endtask

	task automatic drain_replies();
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t which, input logic [EXT_W-1:0] value);
		drain_replies();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (which)
			REG_SIZE_X: ext_x = value;
			REG_SIZE_Y: ext_y = value;
			REG_SIZE_Z: ext_z = value;
			REG_MIN_NBR: nbr_thresh = value[THR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_extents(input int sx, input int sy, input int sz);
		write_reg(REG_SIZE_X, EXT_W'(sx));
		write_reg(REG_SIZE_Y, EXT_W'(sy));
		write_reg(REG_SIZE_Z, EXT_W'(sz));
	endtask

	task automatic load_volume(input int miss_pct);
		int vol;
		vol = int'(ext_x) * int'(ext_y) * int'(ext_z);
		for (int i = 0; i < vol; i++)
			issue_word(CMD_WRITE, 15'(i), rand_sample(), $urandom_range(99, 0) < miss_pct);
	endtask

	task automatic test_store_extremes();
		word_gap_pct = 20;
		stall_pct = 20;
		issue_word(CMD_WRITE, 15'h0000, 16'sh7fff, 1'b0);
		issue_word(CMD_WRITE, 15'h7fff, 16'sh8000, 1'b0);
		issue_word(CMD_WRITE, 15'h5555, 16'sh5555, 1'b0);
		issue_word(CMD_WRITE, 15'h2aaa, 16'shaaaa, 1'b0);
		issue_word(CMD_WRITE, 15'h4000, 16'sh1234, 1'b1);
		issue_word(CMD_READ, 15'h0000, 16'sh0000, 1'b0);
		issue_word(CMD_READ, 15'h7fff, 16'shffff, 1'b1);
		issue_word(CMD_READ, 15'h5555, 16'sh0000, 1'b0);
		issue_word(CMD_READ, 15'h2aaa, 16'sh0000, 1'b0);
		issue_word(CMD_READ, 15'h4000, 16'sh0000, 1'b0);
		issue_word(CMD_NONE, 15'h7fff, 16'shffff, 1'b1);
		issue_word(CMD_NONE, 15'h0000, 16'sh0000, 1'b0);
		issue_word(CMD_WRITE, 15'h7fff, 16'sh7fff, 1'b1);
		issue_word(CMD_READ, 15'h7fff, 16'sh0000, 1'b0);
	endtask

	// center voxel of a 3x3x3 cube, tie rounding and threshold edges
	task automatic test_fill_rounding();
		word_gap_pct = 0;
		stall_pct = 0;
		set_extents(3, 3, 3);
		write_reg(REG_MIN_NBR, 25);
		for (int i = 0; i < 27; i++)
			issue_word(CMD_WRITE, 15'(i), (i == 0) ? -16'sd13 : 16'sd0, i == 13);
		issue_word(CMD_RUN, 15'h0, 16'sh0, 1'b0);
		issue_word(CMD_READ, 15'd13, 16'sh0, 1'b0);
		issue_word(CMD_WRITE, 15'd13, 16'sh0, 1'b1);
		write_reg(REG_MIN_NBR, 26);
		issue_word(CMD_RUN, 15'h0, 16'sh0, 1'b0);
		write_reg(REG_MIN_NBR, 31);
		issue_word(CMD_RUN, 15'h0, 16'sh0, 1'b0);
		write_reg(REG_MIN_NBR, 25);
		issue_word(CMD_WRITE, 15'd0, 16'sd13, 1'b0);
		issue_word(CMD_RUN, 15'h0, 16'sh0, 1'b0);
		issue_word(CMD_READ, 15'd13, 16'sh0, 1'b0);
		word_gap_pct = 30;
		stall_pct = 30;
		write_reg(REG_MIN_NBR, 0);
		for (int i = 0; i < 27; i++)
			issue_word(CMD_WRITE, 15'(i), 16'sh8000, i == 13);
		issue_word(CMD_RUN, 15'h0, 16'sh0, 1'b0);
		issue_word(CMD_READ, 15'd13, 16'sh0, 1'b0);
		issue_word(CMD_READ, 15'd26, 16'sh0, 1'b0);
	endtask

	// runs that must not touch the store: empty interior or volume too large
	task automatic test_extent_limits();
		set_extents(2, 3, 3);
		issue_word(CMD_RUN, 15'h0, 16'sh0, 1'b0);
		set_extents(1024, 1024, 1024);
		issue_word(CMD_RUN, 15'h0, 16'sh0, 1'b0);
		set_extents(2047, 2047, 2047);
		issue_word(CMD_RUN, 15'h0, 16'sh0, 1'b0);
		set_extents(1024, 32, 1);
		issue_word(CMD_RUN, 15'h0, 16'sh0, 1'b0);
		set_extents(33, 33, 33);
		issue_word(CMD_RUN, 15'h0, 16'sh0, 1'b0);
		set_extents(0, 33, 33);
		issue_word(CMD_RUN, 15'h0, 16'sh0, 1'b0);
	endtask

	task automatic test_random_volumes();
		int pace_opts [3] = '{0, 15, 50};
		int miss_pct, pick, vol, thr, long_axis;
		for (int phase = 0; phase < 3; phase++) begin
			word_gap_pct = pace_opts[$urandom_range(2, 0)];
			stall_pct = pace_opts[$urandom_range(2, 0)];
			if ($urandom_range(3, 0) == 0) begin
				long_axis = $urandom_range(2, 0);
				set_extents((long_axis == 0) ? $urandom_range(16, 8) : 3,
					(long_axis == 1) ? $urandom_range(16, 8) : 3,
					(long_axis == 2) ? $urandom_range(16, 8) : 3);
			end else begin
				set_extents($urandom_range(5, 3), $urandom_range(5, 3), $urandom_range(5, 3));
			end
			pick = $urandom_range(9, 0);
			if (phase == 0)
				thr = 0;
			else if (pick < 5)
				thr = $urandom_range(6, 0);
			else if (pick < 8)
				thr = $urandom_range(20, 7);
			else
				thr = $urandom_range(31, 21);
			write_reg(REG_MIN_NBR, EXT_W'(thr));
			miss_pct = $urandom_range(70, 10);
			load_volume(miss_pct);
			vol = int'(ext_x) * int'(ext_y) * int'(ext_z);
			for (int op = 0; op < 30; op++) begin
				pick = $urandom_range(99, 0);
				if (pick < 35)
					issue_word(CMD_WRITE, 15'($urandom_range(vol - 1, 0)), rand_sample(),
						$urandom_range(99, 0) < miss_pct);
				else if (pick < 45)
					issue_word(CMD_WRITE, 15'($urandom), rand_sample(),
						1'($urandom_range(1, 0)));
				else if (pick < 80)
					issue_word(CMD_READ,
						15'(known_list[$urandom_range(known_list.size() - 1, 0)]),
						16'($urandom), 1'($urandom_range(1, 0)));
				else if (pick < 92)
					issue_word(CMD_RUN, 15'($urandom), 16'($urandom),
						1'($urandom_range(1, 0)));
				else
					issue_word(CMD_NONE, 15'($urandom), 16'($urandom),
						1'($urandom_range(1, 0)));
			end
		end
	endtask

	always @(posedge clk) begin
		voxel_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("result word with nothing expected");
			end else begin
				want = pending_replies.pop_front();
				if ($signed(m_tdata[15:0]) !== $signed(want.value))
					report_mismatch($sformatf("read_value got %0d expected %0d",
						$signed(m_tdata[15:0]), $signed(want.value)));
				if (m_tdata[16] !== want.miss)
					report_mismatch($sformatf("read_missing got %0d expected %0d",
						m_tdata[16], want.miss));
				if (m_tdata[32:17] !== want.filled)
					report_mismatch($sformatf("filled_count got %0d expected %0d",
						m_tdata[32:17], want.filled));
				if (m_tuser !== want.status)
					report_mismatch($sformatf("status got %0d expected %0d",
						m_tuser, want.status));
			end
		end
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else begin
			m_tready <= 1'b1;
			rx_hold = pick_gap(stall_pct);
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SIZE_X;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_WRITE;
		ext_x = 32;
		ext_y = 32;
		ext_z = 32;
		nbr_thresh = 0;
		word_gap_pct = 0;
		stall_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_store_extremes();
		test_fill_rounding();
		test_extent_limits();
		test_random_volumes();
		drain_replies();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
